// ===== rtl/rws_pkg.sv =====
// Shared types and constants for the roulette wheel selector.
`default_nettype none
package rws_pkg;

	localparam int FRAC_W    = 16;
	localparam int TOTAL_W   = 24;
	localparam int POP_W     = 9;
	localparam int IN_IDX_W  = 8;
	localparam int OUT_IDX_W = 8;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR,
		ST_MUL,
		ST_WALK,
		ST_FALL,
		ST_OUT
	} rws_state_t;

endpackage
`default_nettype wire

// ===== rtl/rws_mod_unit.sv =====
// Bit-serial restoring remainder unit: dividend modulo divisor, one bit per cycle.
`default_nettype none
module rws_mod_unit #(
	parameter int DIVISOR_W = 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rws_pkg::FRAC_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]       divisor,
	output logic                       busy,
	output logic [DIVISOR_W-1:0]       remainder
);
	import rws_pkg::*;

	localparam int CNT_W = $clog2(FRAC_W + 1);

	logic [CNT_W-1:0]     cnt_q;
	logic [FRAC_W-1:0]    dvd_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W-1:0] rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[FRAC_W-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = DIVISOR_W'(trial - {1'b0, dvs_q});
		end else begin
			rem_next = trial[DIVISOR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(FRAC_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[FRAC_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign busy      = (cnt_q != '0);
	assign remainder = rem_q;

endmodule
`default_nettype wire

// ===== rtl/roulette_wheel_selector_top.sv =====
// Roulette wheel selector top level: fitness table memory, running total and walk.
//
//   channel | signals                          | transfer
//   --------+----------------------------------+--------------------------------
//   in      | in_valid in_ready + item fields  | write entry or select request
//   out     | out_valid out_ready + results    | one per select request
//   cfg     | cfg_valid cfg_ready cfg_data     | population size, always ready
//
// A write reads the old entry on acceptance, then writes back and adjusts the total in ST_WR.
// A select walks the table from entry 0, reading one table entry per cycle, up to
// entry n - 1, n the effective population size; a fallback waits after the walk
// for the bit-serial remainder unit, which runs alongside it.
// After reset the table is cleared, one entry per cycle, before in_ready rises.
// A stalled output holds the result; the next item is taken once the result
// sits in the output register.
`default_nettype none
module roulette_wheel_selector_top #(
	parameter int MAX_POPULATION = 256,
	parameter int FITNESS_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [rws_pkg::IN_IDX_W-1:0]  entry_index,
	input  logic [rws_pkg::FRAC_W-1:0]    fitness,
	input  logic [rws_pkg::FRAC_W-1:0]    random_fraction,
	input  logic [rws_pkg::FRAC_W-1:0]    fallback_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rws_pkg::OUT_IDX_W-1:0] selected_index,
	output logic                          used_fallback,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rws_pkg::POP_W-1:0]     cfg_data
);
	import rws_pkg::*;

	localparam int IDX_W   = $clog2(MAX_POPULATION);
	localparam int NW      = (IDX_W + 1 > POP_W) ? IDX_W + 1 : POP_W;
	localparam int FW      = FITNESS_BITS;
	localparam int CUM_W   = FW + IDX_W;
	localparam int THR_W   = FRAC_W + TOTAL_W;
	localparam int CMP_W   = (CUM_W + FRAC_W > THR_W) ? CUM_W + FRAC_W : THR_W;

	rws_state_t state_q, state_d;

	logic [FW-1:0]      fitness_mem_q [MAX_POPULATION];
	logic [FW-1:0]      rd_data_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [FW-1:0]      mem_wdata;

	logic [POP_W-1:0]   pop_q;
	logic [TOTAL_W-1:0] total_q;
	logic [IDX_W-1:0]   clr_idx_q;
	logic [IN_IDX_W-1:0] idx_q;
	logic [FW-1:0]      fit_q;
	logic [FRAC_W-1:0]  r_q;
	logic [FRAC_W-1:0]  fb_val_q;
	logic [IDX_W-1:0]   last_q;
	logic [THR_W-1:0]   threshold_q;
	logic [CUM_W-1:0]   cum_q;
	logic [CUM_W-1:0]   cum_next;
	logic [IDX_W-1:0]   chk_idx_q;
	logic [OUT_IDX_W-1:0] res_idx_q;
	logic               res_fb_q;
	logic               out_valid_q;
	logic [OUT_IDX_W-1:0] sel_q;
	logic               used_fb_q;

	logic [NW-1:0]      pop_ext;
	logic [NW-1:0]      eff_n;
	logic               in_xfer;
	logic               wr_in_range;
	logic               hit;
	logic               is_last;
	logic               out_load;
	logic               mod_start;
	logic               mod_busy;
	logic [NW-1:0]      mod_rem;

	assign in_xfer  = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		pop_ext = NW'(pop_q);
		if (pop_ext == '0) begin
			eff_n = NW'(1);
		end else if (pop_ext > NW'(MAX_POPULATION)) begin
			eff_n = NW'(MAX_POPULATION);
		end else begin
			eff_n = pop_ext;
		end
	end

	assign wr_in_range = (32'(idx_q) < 32'(MAX_POPULATION));
	assign cum_next    = cum_q + CUM_W'(rd_data_q);
	assign hit         = (CMP_W'({cum_next, {FRAC_W{1'b0}}}) > CMP_W'(threshold_q));
	assign is_last     = (chk_idx_q == last_q);
	assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = IDX_W'(idx_q);
		mem_wdata = fit_q;
		rd_addr   = IDX_W'(entry_index);
		mod_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
				mem_wdata = '0;
				if (clr_idx_q == IDX_W'(MAX_POPULATION - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (command == CMD_SELECT) ? ST_MUL : ST_WR;
				end
			end
			ST_WR: begin
				mem_we  = wr_in_range;
				state_d = ST_IDLE;
			end
			ST_MUL: begin
				rd_addr   = '0;
				mod_start = 1'b1;
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				rd_addr = chk_idx_q + 1'b1;
				if (hit) begin
					state_d = ST_OUT;
				end else if (is_last) begin
					state_d = ST_FALL;
				end
			end
			ST_FALL: begin
				if (!mod_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fitness_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= fitness_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q     <= POP_W'(256);
			total_q   <= '0;
			clr_idx_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pop_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (state_q == ST_WR && wr_in_range) begin
				total_q <= total_q - TOTAL_W'(rd_data_q) + TOTAL_W'(fit_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			idx_q    <= entry_index;
			fit_q    <= FW'(fitness);
			r_q      <= random_fraction;
			fb_val_q <= fallback_value;
			last_q   <= IDX_W'(eff_n - 1'b1);
		end
		if (state_q == ST_MUL) begin
			threshold_q <= THR_W'(r_q) * THR_W'(total_q);
			cum_q       <= '0;
			chk_idx_q   <= '0;
		end
		if (state_q == ST_WALK) begin
			cum_q     <= cum_next;
			chk_idx_q <= chk_idx_q + 1'b1;
			res_idx_q <= OUT_IDX_W'(chk_idx_q);
			res_fb_q  <= 1'b0;
		end
		if (state_q == ST_FALL) begin
			res_idx_q <= OUT_IDX_W'(mod_rem);
			res_fb_q  <= 1'b1;
		end
		if (out_load) begin
			sel_q     <= res_idx_q;
			used_fb_q <= res_fb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	rws_mod_unit #(
		.DIVISOR_W(NW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (fb_val_q),
		.divisor  (eff_n),
		.busy     (mod_busy),
		.remainder(mod_rem)
	);

	assign out_valid      = out_valid_q;
	assign selected_index = sel_q;
	assign used_fallback  = used_fb_q;

endmodule
`default_nettype wire
